[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

[hw/rtl/sprle_pkg.sv]
// ----------------------------------------------------------------------------
// sprle_pkg
// shared types, constants and helpers of the sprite run-length encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sprle_pkg;

    localparam int ADDR_W          = 17;
    localparam int DIM_W           = 9;
    localparam int MAX_WRITES      = 7;
    localparam int WCNT_W          = 3;
    localparam int MAX_DIMENSION_D = 256;
    localparam int MAX_RUN_D       = 127;

    // configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RLE_ENABLE   = 2'd2;

    // run header flag marking the last run of a row
    localparam logic LAST_RUN_FLAG = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             rle;
        logic             restart;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_t;

    typedef struct packed {
        wr_t [MAX_WRITES-1:0] ent;
        logic [WCNT_W-1:0]    count;
        logic                 done;
        logic [ADDR_W-1:0]    total;
    } batch_t;

    // clamp a dimension register into 1..maxd
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxd);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > maxd)
            r = maxd;
        return r;
    endfunction

endpackage

[hw/rtl/sprite_run_length_encoder_unit.sv]
// ----------------------------------------------------------------------------
// sprite_run_length_encoder_unit
// encodes raster palette pixels into raw or transparent run-length sprite bytes
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// pixel     in         pixel_valid/stall     pixel_index, is_transparent
// wr        out        wr_valid/stall        write_address, write_byte,
//                                            last_of_item, image_done, total_length
// cfg       in         cfg_valid/ready       cfg_index, cfg_data
//
// a pixel makes 0 to 7 writes, one byte transfer per cycle on wr while wr_stall is low
// a pixel with no writes leaves the input register without using the result buffer;
// other pixels' writes go from the input register into the result buffer, then out on wr
// reset loads width 1, height 1, run-length mode; a write to a listed register restarts the image
// wr_stall holds the result buffer; the input register stalls once it is full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sprite_run_length_encoder_unit #(
    parameter int MAX_DIMENSION = sprle_pkg::MAX_DIMENSION_D,
    parameter int MAX_RUN       = sprle_pkg::MAX_RUN_D
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pixel_valid,
    output logic                         pixel_stall,
    input  logic [7:0]                   pixel_index,
    input  logic                         is_transparent,
    output logic                         wr_valid,
    input  logic                         wr_stall,
    output logic [sprle_pkg::ADDR_W-1:0] write_address,
    output logic [7:0]                   write_byte,
    output logic                         last_of_item,
    output logic                         image_done,
    output logic [sprle_pkg::ADDR_W-1:0] total_length,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [sprle_pkg::DIM_W-1:0]  cfg_data
);

    sprle_pkg::cfg_t   cfg;
    sprle_pkg::batch_t batch;
    logic              load;
    logic              can_load;

    // configuration registers
    sprle_cfg #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // encoder datapath
    sprle_encode #(
        .MAX_RUN(MAX_RUN)
    ) u_encode (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .pixel_valid    (pixel_valid),
        .pixel_stall    (pixel_stall),
        .pixel_index    (pixel_index),
        .is_transparent (is_transparent),
        .can_load       (can_load),
        .load           (load),
        .batch          (batch)
    );

    // write serializer
    sprle_serial u_serial (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .batch         (batch),
        .can_load      (can_load),
        .wr_valid      (wr_valid),
        .wr_stall      (wr_stall),
        .write_address (write_address),
        .write_byte    (write_byte),
        .last_of_item  (last_of_item),
        .image_done    (image_done),
        .total_length  (total_length)
    );

    // assertions
    `ASSERT_SAME(a_load_room, load, can_load)
    `ASSERT_SAME(a_load_count, load, (batch.count != '0) && (batch.count <= 3'd7))
    `ASSERT_NEXT(a_item_continues, wr_valid && !wr_stall && !last_of_item, wr_valid)
    `ASSERT_SAME(a_done_length, wr_valid && image_done, total_length != '0)

endmodule

[hw/rtl/sprle_cfg.sv]
// ----------------------------------------------------------------------------
// sprle_cfg
// configuration registers with clamping and a restart strobe after each write to a listed register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprle_cfg #(
    parameter int MAX_DIMENSION = sprle_pkg::MAX_DIMENSION_D
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [sprle_pkg::DIM_W-1:0] cfg_data,
    output sprle_pkg::cfg_t             cfg
);

    logic [sprle_pkg::DIM_W-1:0] width_reg;
    logic [sprle_pkg::DIM_W-1:0] height_reg;
    logic                        rle_reg;
    logic                        restart_reg;
    logic                        wr_en;
    logic                        known_index;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;

    // only listed registers restart the image
    assign known_index = (cfg_index == sprle_pkg::REG_IMAGE_WIDTH)
                      || (cfg_index == sprle_pkg::REG_IMAGE_HEIGHT)
                      || (cfg_index == sprle_pkg::REG_RLE_ENABLE);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= sprle_pkg::DIM_W'(1);
            height_reg  <= sprle_pkg::DIM_W'(1);
            rle_reg     <= 1'b1;
            restart_reg <= 1'b0;
        end
        else
        begin
            restart_reg <= wr_en & known_index;
            if (wr_en)
            begin
                case (cfg_index)
                    sprle_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    sprle_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    sprle_pkg::REG_RLE_ENABLE:   rle_reg    <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // clamped view for the datapath
    always_comb
    begin
        cfg.width   = sprle_pkg::clamp_dim(width_reg, sprle_pkg::DIM_W'(MAX_DIMENSION));
        cfg.height  = sprle_pkg::clamp_dim(height_reg, sprle_pkg::DIM_W'(MAX_DIMENSION));
        cfg.rle     = rle_reg;
        cfg.restart = restart_reg;
    end

endmodule

[hw/rtl/sprle_encode.sv]
// ----------------------------------------------------------------------------
// sprle_encode
// input register, encoder state and the per-pixel write list
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprle_encode #(
    parameter int MAX_RUN = sprle_pkg::MAX_RUN_D
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sprle_pkg::cfg_t   cfg,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  logic [7:0]        pixel_index,
    input  logic              is_transparent,
    input  logic              can_load,
    output logic              load,
    output sprle_pkg::batch_t batch
);

    localparam int AW = sprle_pkg::ADDR_W;

    // input register
    logic       pv_reg;
    logic [7:0] idx_reg;
    logic       tr_reg;

    // encoder state
    logic [7:0]    col_reg, col_next;
    logic [7:0]    row_reg, row_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] ha_reg, ha_next;
    logic [7:0]    rs_reg, rs_next;
    logic [6:0]    rc_reg, rc_next;
    logic [AW-1:0] pha_reg, pha_next;
    logic [6:0]    pc_reg, pc_next;
    logic          hp_reg, hp_next;
    logic [AW-1:0] rb_reg, rb_next;

    logic advance;
    logic take_in;

    // writes and next state for the pixel in the input register
    always_comb
    begin
        logic [AW-1:0]                  wp, ha, pha, rb, total;
        logic [7:0]                     rs, col, row;
        logic [6:0]                     rc, pc;
        logic                           hp, last, done;
        logic [sprle_pkg::WCNT_W-1:0]   n;
        sprle_pkg::wr_t [sprle_pkg::MAX_WRITES-1:0] wl;
        logic [8:0]                     row_inc;

        wp    = wp_reg;
        ha    = ha_reg;
        pha   = pha_reg;
        rb    = rb_reg;
        rs    = rs_reg;
        rc    = rc_reg;
        pc    = pc_reg;
        hp    = hp_reg;
        col   = col_reg;
        row   = row_reg;
        n     = '0;
        wl    = '0;
        done  = 1'b0;
        total = '0;
        last  = ({1'b0, col_reg} + 9'd1) >= cfg.width;
        row_inc = {1'b0, row_reg} + 9'd1;

        if (cfg.rle)
        begin
            // row start: offset table entry, reserve first run header
            if (col_reg == 8'd0)
            begin
                ha = wp;
                wl[n] = '{addr: {8'd0, row_reg, 1'b0}, data: wp[7:0]};
                n = n + 1'b1;
                wl[n] = '{addr: {8'd0, row_reg, 1'b1}, data: wp[15:8]};
                n = n + 1'b1;
                wp = wp + AW'(2);
                hp = 1'b0;
                rc = '0;
                rs = '0;
            end
            if (!tr_reg)
            begin
                // opaque pixel byte
                if (rc == '0)
                    rs = col_reg;
                wl[n] = '{addr: wp, data: idx_reg};
                n = n + 1'b1;
                wp = wp + AW'(1);
                rc = rc + 7'd1;
                if ((rc >= 7'(MAX_RUN)) || last)
                begin
                    wl[n] = '{addr: ha, data: {last, rc}};
                    n = n + 1'b1;
                    wl[n] = '{addr: ha + AW'(1), data: rs};
                    n = n + 1'b1;
                    pha = ha;
                    pc  = rc;
                    hp  = 1'b1;
                    rc  = '0;
                    rs  = '0;
                    ha  = wp;
                    wp  = wp + AW'(2);
                    if (last)
                    begin
                        // two zero pad bytes after an opaque row end
                        wl[n] = '{addr: ha, data: 8'd0};
                        n = n + 1'b1;
                        wl[n] = '{addr: ha + AW'(1), data: 8'd0};
                        n = n + 1'b1;
                    end
                end
            end
            else if (rc != '0)
            begin
                // transparent pixel closes the open run
                wl[n] = '{addr: ha, data: {last, rc}};
                n = n + 1'b1;
                wl[n] = '{addr: ha + AW'(1), data: rs};
                n = n + 1'b1;
                pha = ha;
                pc  = rc;
                hp  = 1'b1;
                rc  = '0;
                rs  = '0;
                if (!last)
                begin
                    ha = wp;
                    wp = wp + AW'(2);
                end
            end
            else if (last)
            begin
                if (hp)
                begin
                    // mark the prior run last, give back the reserved header
                    wl[n] = '{addr: pha, data: {sprle_pkg::LAST_RUN_FLAG, pc}};
                    n = n + 1'b1;
                    wp = ha;
                end
                else
                begin
                    // empty row
                    wl[n] = '{addr: ha, data: {sprle_pkg::LAST_RUN_FLAG, 7'd0}};
                    n = n + 1'b1;
                    wl[n] = '{addr: ha + AW'(1), data: 8'd0};
                    n = n + 1'b1;
                end
            end
        end
        else
        begin
            // raw byte per pixel
            wl[n] = '{addr: rb + AW'(col_reg), data: tr_reg ? 8'd0 : idx_reg};
            n = n + 1'b1;
        end

        // position update and end of image
        if (last)
        begin
            col = '0;
            row = row_inc[7:0];
            if (row_inc >= cfg.height)
            begin
                done  = 1'b1;
                total = cfg.rle ? wp : (rb + AW'(cfg.width));
                col   = '0;
                row   = '0;
                wp    = {7'd0, cfg.height, 1'b0};
                ha    = '0;
                rs    = '0;
                rc    = '0;
                pha   = '0;
                pc    = '0;
                hp    = 1'b0;
                rb    = '0;
            end
            else
            begin
                rb = rb + AW'(cfg.width);
            end
        end
        else
        begin
            col = col_reg + 8'd1;
        end

        col_next = col;
        row_next = row;
        wp_next  = wp;
        ha_next  = ha;
        rs_next  = rs;
        rc_next  = rc;
        pha_next = pha;
        pc_next  = pc;
        hp_next  = hp;
        rb_next  = rb;

        batch.ent   = wl;
        batch.count = n;
        batch.done  = done;
        batch.total = total;
    end

    // handshake between input register and result buffer
    assign advance     = pv_reg & (can_load | (batch.count == '0));
    assign load        = advance & (batch.count != '0);
    assign pixel_stall = pv_reg & ~advance;
    assign take_in     = pixel_valid & ~pixel_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else if (take_in)
            pv_reg <= 1'b1;
        else if (advance)
            pv_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            idx_reg <= pixel_index;
            tr_reg  <= is_transparent;
        end
    end

    // encoder state, restarted on a write to a listed configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            wp_reg  <= AW'(2);
            ha_reg  <= '0;
            rs_reg  <= '0;
            rc_reg  <= '0;
            pha_reg <= '0;
            pc_reg  <= '0;
            hp_reg  <= 1'b0;
            rb_reg  <= '0;
        end
        else if (cfg.restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
            wp_reg  <= {7'd0, cfg.height, 1'b0};
            ha_reg  <= '0;
            rs_reg  <= '0;
            rc_reg  <= '0;
            pha_reg <= '0;
            pc_reg  <= '0;
            hp_reg  <= 1'b0;
            rb_reg  <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            wp_reg  <= wp_next;
            ha_reg  <= ha_next;
            rs_reg  <= rs_next;
            rc_reg  <= rc_next;
            pha_reg <= pha_next;
            pc_reg  <= pc_next;
            hp_reg  <= hp_next;
            rb_reg  <= rb_next;
        end
    end

endmodule

[hw/rtl/sprle_serial.sv]
// ----------------------------------------------------------------------------
// sprle_serial
// result buffer holding one pixel's writes, sent out one transfer a cycle while wr_stall is low
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprle_serial (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  sprle_pkg::batch_t            batch,
    output logic                         can_load,
    output logic                         wr_valid,
    input  logic                         wr_stall,
    output logic [sprle_pkg::ADDR_W-1:0] write_address,
    output logic [7:0]                   write_byte,
    output logic                         last_of_item,
    output logic                         image_done,
    output logic [sprle_pkg::ADDR_W-1:0] total_length
);

    logic                           bv_reg;
    logic [sprle_pkg::WCNT_W-1:0]   pos_reg;
    sprle_pkg::batch_t              batch_reg;
    logic                           take;
    logic                           at_last;

    assign take     = bv_reg & ~wr_stall;
    assign at_last  = pos_reg == (batch_reg.count - 1'b1);
    assign can_load = ~bv_reg | (take & at_last);

    // buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg  <= 1'b0;
            pos_reg <= '0;
        end
        else if (load)
        begin
            bv_reg  <= 1'b1;
            pos_reg <= '0;
        end
        else if (take)
        begin
            if (at_last)
                bv_reg <= 1'b0;
            else
                pos_reg <= pos_reg + 1'b1;
        end
    end

    // buffer payload
    always_ff @(posedge clk)
    begin
        if (load)
            batch_reg <= batch;
    end

    // current transfer
    assign wr_valid      = bv_reg;
    assign write_address = batch_reg.ent[pos_reg].addr;
    assign write_byte    = batch_reg.ent[pos_reg].data;
    assign last_of_item  = at_last;
    assign image_done    = batch_reg.done;
    assign total_length  = batch_reg.total;

endmodule
